// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/fwir_pkg.sv -----
// ----------------------------------------------------------------------------
// fwir_pkg
// shared types and constants of the fifo with indexed remove
// ----------------------------------------------------------------------------
package fwir_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ    = 3'd0,
      CMD_DEQ    = 3'd1,
      CMD_PEEK   = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_READ   = 3'd4,
      CMD_COUNT  = 3'd5
   } cmd_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic push;
      logic remove;
      logic use_head;
      logic load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic pos_valid;
   } dp_status_type;

endpackage

// ----- rtl/fwir_datapath.sv -----
// ----------------------------------------------------------------------------
// fwir_datapath
// shifting cell chain, entry count and result data register
// ----------------------------------------------------------------------------
module fwir_datapath #(
   parameter int DEPTH      = fwir_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = fwir_pkg::DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fwir_pkg::dp_cmd_type            cmd,
   input  logic [fwir_pkg::VALUE_W-1:0]    value,
   input  logic [fwir_pkg::POS_W-1:0]      position,
   output fwir_pkg::dp_status_type         status,
   output logic [fwir_pkg::VALUE_W-1:0]    data,
   output logic [fwir_pkg::COUNT_W-1:0]    count
);
   import fwir_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic [DATA_WIDTH-1:0] cells_ff [DEPTH];
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [VALUE_W-1:0]    data_ff;
   logic [VALUE_W-1:0]    data_in;

   logic [POS_W-1:0]      pos_m1;
   logic [IDX_W-1:0]      idx;
   logic [DATA_WIDTH-1:0] rd_word;
   logic [DATA_WIDTH-1:0] wr_word;
   logic [VALUE_W-1:0]    rd_ext;

   assign pos_m1  = position - POS_W'(1);
   assign idx     = cmd.use_head ? '0 : IDX_W'(pos_m1);
   assign rd_word = cells_ff[idx];

   generate
      if (DATA_WIDTH >= VALUE_W) begin : g_wide
         assign rd_ext  = rd_word[VALUE_W-1:0];
         assign wr_word = DATA_WIDTH'(value);
      end else begin : g_narrow
         assign rd_ext  = VALUE_W'(rd_word);
         assign wr_word = value[DATA_WIDTH-1:0];
      end
   endgenerate

   assign status.empty     = (count_ff == '0);
   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign status.pos_valid = (position != '0) &&
                             (CMP_W'(position) <= CMP_W'(count_ff));

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
      data_in = data_ff;
      if (cmd.capture) begin
         data_in = cmd.load ? rd_ext : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      data_ff <= data_in;
   end

   // cell chain: each cell loads the word behind it or the incoming word
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (cmd.push && (CNT_W'(i) == count_ff)) begin
            cells_ff[i] <= wr_word;
         end else if (cmd.remove && (i < DEPTH - 1) && (IDX_W'(i) >= idx)) begin
            cells_ff[i] <= cells_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   assign data  = data_ff;
   assign count = COUNT_W'(count_ff);

endmodule

// ----- rtl/fwir_ctrl.sv -----
// ----------------------------------------------------------------------------
// fwir_ctrl
// command decode, handshake and result strobe
// ----------------------------------------------------------------------------
module fwir_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fwir_pkg::CMD_W-1:0]    command,
   input  fwir_pkg::dp_status_type       status,
   output fwir_pkg::dp_cmd_type          cmd,
   output logic                          busy,
   output logic                          rsp_valid,
   output logic                          rsp_ok
);
   import fwir_pkg::*;

   logic busy_ff;
   logic valid_ff;
   logic ok_ff;
   logic accept;
   logic ok_in;

   assign accept = start && !busy_ff;

   always_comb begin
      cmd         = '0;
      ok_in       = 1'b0;
      cmd.capture = accept;
      case (cmd_type'(command))
         CMD_ENQ: begin
            ok_in    = !status.full;
            cmd.push = accept && ok_in;
         end
         CMD_DEQ: begin
            ok_in        = !status.empty;
            cmd.use_head = 1'b1;
            cmd.remove   = accept && ok_in;
            cmd.load     = ok_in;
         end
         CMD_PEEK: begin
            ok_in        = !status.empty;
            cmd.use_head = 1'b1;
            cmd.load     = ok_in;
         end
         CMD_REMOVE: begin
            ok_in      = status.pos_valid;
            cmd.remove = accept && ok_in;
            cmd.load   = ok_in;
         end
         CMD_READ: begin
            ok_in    = status.pos_valid;
            cmd.load = ok_in;
         end
         CMD_COUNT: begin
            ok_in = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= accept;
         ok_ff    <= accept && ok_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp_ok    = ok_ff;

endmodule

// ----- rtl/fifo_with_indexed_remove.sv -----
// ----------------------------------------------------------------------------
// fifo_with_indexed_remove
// bounded fifo of data words with remove and read at a 1-based position
// ----------------------------------------------------------------------------
// One command transaction is taken per clock cycle while busy is low; busy is
// high during reset and for the first cycle after it. The result is registered
// and follows in the cycle after acceptance; it is shown for exactly that cycle
// with rsp_valid; the receiver cannot stall it, so it must take every result as
// it comes. The rate is set by the shifting cell chain, which closes the gap
// left by a remove in the same cycle. No clearing pass runs after reset:
// entries beyond the count are never returned.
module fifo_with_indexed_remove #(
   parameter int DEPTH      = fwir_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = fwir_pkg::DATA_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic        [fwir_pkg::CMD_W-1:0]     req_command,
   input  logic signed [fwir_pkg::VALUE_W-1:0]   req_value,
   input  logic        [fwir_pkg::POS_W-1:0]     req_position,
   output logic                                  rsp_valid,
   output logic                                  rsp_ok,
   output logic signed [fwir_pkg::VALUE_W-1:0]   rsp_data,
   output logic        [fwir_pkg::COUNT_W-1:0]   rsp_count
);
   import fwir_pkg::*;

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [VALUE_W-1:0]  data;

   fwir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req_command),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_ok    (rsp_ok)
   );

   fwir_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .value    (req_value),
      .position (req_position),
      .status   (status),
      .data     (data),
      .count    (rsp_count)
   );

   assign rsp_data = $signed(data);

endmodule

// ----- rtl/fwir_checker.sv -----
// ----------------------------------------------------------------------------
// fwir_sva
// port-level checks of the fifo with indexed remove
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fwir_sva (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic        [fwir_pkg::CMD_W-1:0]   req_command,
   input logic        [fwir_pkg::POS_W-1:0]   req_position,
   input logic                                rsp_valid,
   input logic                                rsp_ok,
   input logic signed [fwir_pkg::VALUE_W-1:0] rsp_data
);
   import fwir_pkg::*;

   logic accept;
   logic enq_cmd;
   logic reads_pos;

   assign accept    = start && !busy;
   assign enq_cmd   = (req_command == CMD_ENQ);
   assign reads_pos = (req_command == CMD_REMOVE) || (req_command == CMD_READ);

   // every transaction gets exactly one result
   `ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid)
   `ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !accept, !rsp_valid)
   // failures and enqueues return zero data
   `ASSERT_IMPLIES(a_fail_zero, clock, reset, rsp_valid && !rsp_ok, rsp_data == '0)
   `ASSERT_NEXT(a_enq_zero, clock, reset, accept && enq_cmd, rsp_data == '0)
   // position zero never succeeds
   `ASSERT_NEXT(a_pos_zero, clock, reset, accept && reads_pos && (req_position == '0), !rsp_ok)

endmodule

bind fifo_with_indexed_remove fwir_sva u_fwir_sva (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_command  (req_command),
   .req_position (req_position),
   .rsp_valid    (rsp_valid),
   .rsp_ok       (rsp_ok),
   .rsp_data     (rsp_data)
);
